@@ src/assert_macros.svh @@
// Assertion macros shared by the option scanner RTL.
// Needs a clock named clock and a reset named reset in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define DACS_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

`define DACS_ASSERT_IMPLIES(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

`endif

@@ src/dacs_pkg.sv @@
// Types and constants for the DHCP ACK option scanner.
// No dependencies; used by dacs_step and the top level.
package dacs_pkg;

   typedef enum logic [1:0] {
      PH_CODE,
      PH_LEN,
      PH_VAL
   } phase_type;

   localparam logic [7:0] OPT_PAD     = 8'd0;
   localparam logic [7:0] OPT_SUBNET  = 8'd1;
   localparam logic [7:0] OPT_ROUTER  = 8'd3;
   localparam logic [7:0] OPT_DNS     = 8'd6;
   localparam logic [7:0] OPT_LEASE   = 8'd51;
   localparam logic [7:0] OPT_RENEWAL = 8'd58;
   localparam logic [7:0] OPT_END     = 8'd255;

   localparam logic [2:0] KIND_SUBNET = 3'd0;
   localparam logic [2:0] KIND_ROUTER = 3'd1;
   localparam logic [2:0] KIND_DNS    = 3'd2;
   localparam logic [2:0] KIND_LEASE  = 3'd3;
   localparam logic [2:0] KIND_DONE   = 3'd4;

   localparam logic [31:0] LEASE_INFINITE = 32'hffff_ffff;
   localparam logic [9:0]  MS_PER_SEC     = 10'd1000;
   localparam logic [2:0]  VALUE_BYTES    = 3'd4;

   typedef struct packed {
      phase_type   phase;
      logic [7:0]  option_code;
      logic [7:0]  bytes_left;
      logic [31:0] value_acc;
      logic [2:0]  value_count;
      logic        finished;
   } scan_type;

   localparam scan_type SCAN_RESET = '{
      phase:       PH_CODE,
      option_code: 8'd0,
      bytes_left:  8'd0,
      value_acc:   32'd0,
      value_count: 3'd0,
      finished:    1'b0
   };

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] value;
      logic        last;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type res0;
      result_type res1;
   } step_out_type;

endpackage

@@ src/dacs_if.sv @@
// Valid/ready channel interfaces for the option scanner: byte input and result output.
// Depends on nothing; payload widths follow the scanner's field list.
interface dacs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       first_byte;
   logic       packet_end;

   modport source (output valid, output data_byte, output first_byte, output packet_end,
                   input ready);
   modport sink (input valid, input data_byte, input first_byte, input packet_end,
                 output ready);
endinterface

interface dacs_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [31:0] value;
   logic        last;

   modport source (output valid, output kind, output value, output last, input ready);
   modport sink (input valid, input kind, input value, input last, output ready);
endinterface

@@ src/dacs_step.sv @@
// Next-state and result logic of the option scanner for one byte.
// Depends on dacs_pkg.
module dacs_step (
   input  dacs_pkg::scan_type     cur_state,
   input  logic [7:0]             data_byte,
   input  logic                   first_byte,
   input  logic                   packet_end,
   output dacs_pkg::scan_type     nxt_state,
   output dacs_pkg::step_out_type step_out
);

   dacs_pkg::scan_type st;
   dacs_pkg::scan_type nxt;
   logic               emit_req;
   logic               done;
   logic               kind_hit;
   logic [2:0]         ekind;
   logic [31:0]        shifted;
   logic [41:0]        prod;
   logic [31:0]        evalue;
   logic               emit_valid;

   always_comb begin
      st       = first_byte ? dacs_pkg::SCAN_RESET : cur_state;
      nxt      = st;
      emit_req = 1'b0;
      done     = 1'b0;
      if (!st.finished) begin
         unique case (st.phase)
            dacs_pkg::PH_CODE: begin
               if (data_byte == dacs_pkg::OPT_END) begin
                  nxt.finished = 1'b1;
                  done         = 1'b1;
               end else if (data_byte != dacs_pkg::OPT_PAD) begin
                  nxt.option_code = data_byte;
                  nxt.phase       = dacs_pkg::PH_LEN;
               end
            end
            dacs_pkg::PH_LEN: begin
               nxt.bytes_left  = data_byte;
               nxt.value_acc   = 32'd0;
               nxt.value_count = 3'd0;
               if (data_byte == 8'd0) begin
                  emit_req  = 1'b1;
                  nxt.phase = dacs_pkg::PH_CODE;
               end else begin
                  nxt.phase = dacs_pkg::PH_VAL;
               end
            end
            default: begin
               if (st.value_count < dacs_pkg::VALUE_BYTES) begin
                  nxt.value_acc   = {st.value_acc[23:0], data_byte};
                  nxt.value_count = st.value_count + 3'd1;
               end
               nxt.bytes_left = st.bytes_left - 8'd1;
               if (nxt.bytes_left == 8'd0) begin
                  emit_req  = 1'b1;
                  nxt.phase = dacs_pkg::PH_CODE;
               end
            end
         endcase
         if (packet_end && !nxt.finished) begin
            if (nxt.phase != dacs_pkg::PH_CODE) begin
               if (nxt.phase == dacs_pkg::PH_LEN) begin
                  nxt.value_acc   = 32'd0;
                  nxt.value_count = 3'd0;
               end
               emit_req = 1'b1;
            end
            nxt.phase      = dacs_pkg::PH_CODE;
            nxt.bytes_left = 8'd0;
            nxt.finished   = 1'b1;
            done           = 1'b1;
         end
      end
   end

   always_comb begin
      kind_hit = 1'b1;
      ekind    = dacs_pkg::KIND_SUBNET;
      unique case (nxt.option_code)
         dacs_pkg::OPT_SUBNET:  ekind = dacs_pkg::KIND_SUBNET;
         dacs_pkg::OPT_ROUTER:  ekind = dacs_pkg::KIND_ROUTER;
         dacs_pkg::OPT_DNS:     ekind = dacs_pkg::KIND_DNS;
         dacs_pkg::OPT_LEASE:   ekind = dacs_pkg::KIND_LEASE;
         dacs_pkg::OPT_RENEWAL: ekind = dacs_pkg::KIND_LEASE;
         default:               kind_hit = 1'b0;
      endcase
   end

   // pad short values with zero low-order bytes
   always_comb begin
      unique case (nxt.value_count)
         3'd0:    shifted = 32'd0;
         3'd1:    shifted = {nxt.value_acc[7:0], 24'd0};
         3'd2:    shifted = {nxt.value_acc[15:0], 16'd0};
         3'd3:    shifted = {nxt.value_acc[23:0], 8'd0};
         default: shifted = nxt.value_acc;
      endcase
   end

   always_comb begin
      prod = {10'd0, shifted} * {32'd0, dacs_pkg::MS_PER_SEC};
      if (ekind == dacs_pkg::KIND_LEASE && shifted != dacs_pkg::LEASE_INFINITE) begin
         evalue = prod[31:0];
      end else begin
         evalue = shifted;
      end
   end

   always_comb begin
      emit_valid          = emit_req && kind_hit;
      step_out.count      = {1'b0, emit_valid} + {1'b0, done};
      step_out.res0.kind  = emit_valid ? ekind : dacs_pkg::KIND_DONE;
      step_out.res0.value = emit_valid ? evalue : 32'd0;
      step_out.res0.last  = !(emit_valid && done);
      step_out.res1.kind  = dacs_pkg::KIND_DONE;
      step_out.res1.value = 32'd0;
      step_out.res1.last  = 1'b1;
   end

   assign nxt_state = nxt;

endmodule

@@ src/dhcp_ack_option_scanner.sv @@
// DHCP ACK option scanner: one option byte per cycle while the output buffer has room.
// A byte with two results fills both output buffer slots; a later byte with results waits for room.
// A taken byte is held in the input register; its results are registered in the output buffer.
// Reset (synchronous, active high) clears scan state and all valid flags.
// Depends on dacs_pkg, dacs_if, dacs_step and assert_macros.svh.
`include "assert_macros.svh"

module dhcp_ack_option_scanner (
   input logic   clock,
   input logic   reset,
   dacs_req_if.sink   req_chan,
   dacs_rsp_if.source rsp_chan
);

   logic                   s1_valid_ff, s1_valid_in;
   logic [7:0]             s1_byte_ff;
   logic                   s1_first_ff;
   logic                   s1_end_ff;
   dacs_pkg::scan_type     scan_ff, scan_in;
   logic [1:0]             out_cnt_ff, out_cnt_in;
   dacs_pkg::result_type   out0_ff, out0_in;
   dacs_pkg::result_type   out1_ff, out1_in;
   dacs_pkg::step_out_type step_out;
   logic                   req_take;
   logic                   rsp_take;
   logic                   buf_free;
   logic                   advance;

   dacs_step u_step (
      .cur_state  (scan_ff),
      .data_byte  (s1_byte_ff),
      .first_byte (s1_first_ff),
      .packet_end (s1_end_ff),
      .nxt_state  (scan_in),
      .step_out   (step_out)
   );

   assign rsp_take = rsp_chan.valid && rsp_chan.ready;
   assign buf_free = (out_cnt_ff == 2'd0) || (out_cnt_ff == 2'd1 && rsp_chan.ready);
   assign advance  = s1_valid_ff && (step_out.count == 2'd0 || buf_free);
   assign req_chan.ready = !s1_valid_ff || advance;
   assign req_take = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid = out_cnt_ff != 2'd0;
   assign rsp_chan.kind  = out0_ff.kind;
   assign rsp_chan.value = out0_ff.value;
   assign rsp_chan.last  = out0_ff.last;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_cnt_in = out_cnt_ff;
      out0_in    = out0_ff;
      out1_in    = out1_ff;
      if (advance && step_out.count != 2'd0) begin
         out_cnt_in = step_out.count;
         out0_in    = step_out.res0;
         out1_in    = step_out.res1;
      end else if (rsp_take) begin
         out_cnt_in = out_cnt_ff - 2'd1;
         out0_in    = out1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         scan_ff     <= dacs_pkg::SCAN_RESET;
         out_cnt_ff  <= 2'd0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         out_cnt_ff  <= out_cnt_in;
         if (advance) begin
            scan_ff <= scan_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_byte_ff  <= req_chan.data_byte;
         s1_first_ff <= req_chan.first_byte;
         s1_end_ff   <= req_chan.packet_end;
      end
      out0_ff <= out0_in;
      out1_ff <= out1_in;
   end

   `DACS_ASSERT_IMPLIES(a_pair_order, out_cnt_ff == 2'd2, !out0_ff.last && out1_ff.last, "result pair out of order")
   `DACS_ASSERT_IMPLIES(a_done_clean, rsp_chan.valid && rsp_chan.kind == dacs_pkg::KIND_DONE, rsp_chan.last && rsp_chan.value == 32'd0, "bad completion result")
   `DACS_ASSERT_IMPLIES(a_code_no_left, scan_ff.phase == dacs_pkg::PH_CODE, scan_ff.bytes_left == 8'd0, "value bytes left while expecting a code")
   `DACS_ASSERT_ALWAYS(a_cnt_range, out_cnt_ff != 2'd3, "output buffer overfilled")

endmodule
